### rtl/mau_pkg.sv
// mau_pkg: shared types and constants of the modular arithmetic unit
// opcodes, sequencer states, adder control struct and default widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mau_pkg;

   // default residue and exponent widths
   localparam int RESIDUE_WIDTH_DEF  = 30;
   localparam int EXPONENT_WIDTH_DEF = 31;

   // request field widths
   localparam int OP_WIDTH      = 4;
   localparam int OPERAND_WIDTH = 32;

   // modulus after reset
   localparam longint unsigned MODULUS_RESET = 64'd998244353;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD    = 4'd0,
      OP_SUB    = 4'd1,
      OP_MUL    = 4'd2,
      OP_DIV    = 4'd3,
      OP_POW    = 4'd4,
      OP_INV    = 4'd5,
      OP_INC    = 4'd6,
      OP_DEC    = 4'd7,
      OP_REDUCE = 4'd8
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED,
      ST_NEG,
      ST_OPER,
      ST_MUL_DBL,
      ST_MUL_ADD,
      ST_MUL_END,
      ST_POW_BIT,
      ST_FINISH
   } state_type;

   // what follows a finished modular multiplication
   typedef enum logic [1:0] {
      RET_SQR,
      RET_MULB,
      RET_FINAL
   } ret_type;

   // control of the shared modular adder
   typedef struct packed {
      logic sub;
      logic cin;
   } modop_type;

endpackage

`default_nettype wire

### rtl/modular_arithmetic_unit.sv
// a request runs bit-serial reduction of each operand, a negation per negative operand, one
// operation step and a finish step; with modulus below two it goes straight to finish
// mul adds a shift-and-add multiplication, pow/inv a square-and-multiply loop, and div one
// multiplication more after the inversion
// throughput: one request in flight; a waiting response only holds the sequencer at its finish
// synchronous active-high reset clears the sequencer and response valid, loads modulus 998244353
`timescale 1ns / 1ps
`default_nettype none

module modular_arithmetic_unit
   import mau_pkg::*;
#(
   parameter int RESIDUE_WIDTH  = RESIDUE_WIDTH_DEF,
   parameter int EXPONENT_WIDTH = EXPONENT_WIDTH_DEF
) (
   input  wire  logic                clock,
   input  wire  logic                reset,
   // request channel
   input  wire  logic                req_tvalid,
   output logic                      req_tready,
   input  wire  logic [63:0]         req_tdata,   // operand_a [31:0], operand_b [63:32]
   input  wire  logic [OP_WIDTH-1:0] req_tuser,   // op [3:0]
   // response channel
   output logic                      rsp_tvalid,
   input  wire  logic                rsp_tready,
   output logic [((RESIDUE_WIDTH+7)/8)*8-1:0] rsp_tdata, // result [RESIDUE_WIDTH-1:0], zeros above
   output logic                      rsp_tuser,   // status [0]
   // modulus register write
   input  wire  logic                csr_tvalid,
   output logic                      csr_tready,
   input  wire  logic [((RESIDUE_WIDTH+7)/8)*8-1:0] csr_tdata  // modulus [RESIDUE_WIDTH-1:0]
);

   localparam int RW     = RESIDUE_WIDTH;
   localparam int RSP_DW = ((RESIDUE_WIDTH + 7) / 8) * 8;
   // a nonnegative 32-bit exponent never has more than 31 live bits
   localparam int EW_EFF = (EXPONENT_WIDTH < OPERAND_WIDTH - 1) ? EXPONENT_WIDTH
                                                                  : OPERAND_WIDTH - 1;
   // exponent register also holds modulus minus two
   localparam int XW     = (EW_EFF > RW) ? EW_EFF : RW;
   localparam int XCW    = $clog2(XW + 1);
   localparam int MAXC   = (OPERAND_WIDTH > RW) ? OPERAND_WIDTH : RW;
   localparam int CW     = $clog2(MAXC + 1);
   localparam logic [RW-1:0] MOD_RST = RW'(MODULUS_RESET);

   // request fields
   op_type                   req_op;
   logic [OPERAND_WIDTH-1:0] req_a;
   logic [OPERAND_WIDTH-1:0] req_b;
   logic [OPERAND_WIDTH-1:0] req_a_mag;
   logic [OPERAND_WIDTH-1:0] b_mag;

   // sequencer and datapath registers
   state_type                state_ff,     state_in;
   ret_type                  ret_ff,       ret_in;
   op_type                   op_ff,        op_in;
   logic [OPERAND_WIDTH-1:0] b_raw_ff,     b_raw_in;
   logic [OPERAND_WIDTH-1:0] mag_ff,       mag_in;
   logic                     neg_ff,       neg_in;
   logic                     sel_b_ff,     sel_b_in;
   logic [CW-1:0]            cnt_ff,       cnt_in;
   logic [RW-1:0]            a_ff,         a_in;
   logic [RW-1:0]            b_ff,         b_in;
   logic [RW-1:0]            acc_ff,       acc_in;
   logic [RW-1:0]            x_ff,         x_in;
   logic [RW-1:0]            y_ff,         y_in;
   logic [RW-1:0]            r_ff,         r_in;
   logic [RW-1:0]            base_ff,      base_in;
   logic [XW-1:0]            exp_ff,       exp_in;
   logic [XCW-1:0]           exp_cnt_ff,   exp_cnt_in;
   logic                     seen_ff,      seen_in;
   logic [RW-1:0]            res_ff,       res_in;
   logic                     status_ff,    status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0]            rsp_res_ff,   rsp_res_in;
   logic                     rsp_stat_ff,  rsp_stat_in;
   logic [RW-1:0]            modulus_ff,   modulus_in;

   // shared modular adder
   modop_type     ua_ctl;
   logic [RW-1:0] ua_x;
   logic [RW-1:0] ua_y;
   logic [RW-1:0] ua_sum;

   assign req_op    = op_type'(req_tuser);
   assign req_a     = req_tdata[OPERAND_WIDTH-1:0];
   assign req_b     = req_tdata[2*OPERAND_WIDTH-1:OPERAND_WIDTH];
   // two's complement magnitude; the most negative value maps to 2^31 exactly
   assign req_a_mag = req_a[OPERAND_WIDTH-1] ? (~req_a + 1'b1) : req_a;
   assign b_mag     = b_raw_ff[OPERAND_WIDTH-1] ? (~b_raw_ff + 1'b1) : b_raw_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_tready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DW'(rsp_res_ff);
   assign rsp_tuser  = rsp_stat_ff;

   mau_modadd #(
      .WIDTH (RW)
   ) u_modadd (
      .ctl     (ua_ctl),
      .modulus (modulus_ff),
      .x       (ua_x),
      .y       (ua_y),
      .sum     (ua_sum)
   );

   // operand selection for the shared adder
   always_comb begin
      ua_ctl = '{sub: 1'b0, cin: 1'b0};
      ua_x   = acc_ff;
      ua_y   = acc_ff;
      unique case (state_ff)
         ST_RED: begin
            // shift one magnitude bit into the residue: 2*acc + bit
            ua_ctl.cin = mag_ff[OPERAND_WIDTH-1];
         end
         ST_NEG: begin
            // negative operand: 0 - residue
            ua_ctl.sub = 1'b1;
            ua_x       = '0;
         end
         ST_OPER: begin
            ua_x = a_ff;
            ua_y = b_ff;
            unique case (op_ff)
               OP_SUB: ua_ctl.sub = 1'b1;
               OP_INC: begin
                  ua_y       = '0;
                  ua_ctl.cin = 1'b1;
               end
               OP_DEC: begin
                  ua_y       = RW'(1);
                  ua_ctl.sub = 1'b1;
               end
               default: ;
            endcase
         end
         ST_MUL_ADD: ua_y = x_ff;
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      logic store;

      store        = 1'b0;
      state_in     = state_ff;
      ret_in       = ret_ff;
      op_in        = op_ff;
      b_raw_in     = b_raw_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      sel_b_in     = sel_b_ff;
      cnt_in       = cnt_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      acc_in       = acc_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      r_in         = r_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      exp_cnt_in   = exp_cnt_ff;
      seen_in      = seen_ff;
      res_in       = res_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_res_in   = rsp_res_ff;
      rsp_stat_in  = rsp_stat_ff;
      modulus_in   = (csr_tvalid && csr_tready) ? csr_tdata[RW-1:0] : modulus_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_op;
               b_raw_in  = req_b;
               mag_in    = req_a_mag;
               neg_in    = req_a[OPERAND_WIDTH-1];
               sel_b_in  = 1'b0;
               acc_in    = '0;
               cnt_in    = CW'(OPERAND_WIDTH);
               res_in    = '0;
               status_in = 1'b0;
               // modulus zero or one: every request answers zero
               state_in  = (modulus_ff < RW'(2)) ? ST_FINISH : ST_RED;
            end
         end

         ST_RED: begin
            acc_in = ua_sum;
            mag_in = mag_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               if (neg_ff) begin
                  state_in = ST_NEG;
               end else begin
                  store = 1'b1;
               end
            end
         end

         ST_NEG: store = 1'b1;

         ST_OPER: begin
            unique case (op_ff)
               OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
                  res_in   = ua_sum;
                  state_in = ST_FINISH;
               end
               OP_REDUCE: begin
                  res_in   = a_ff;
                  state_in = ST_FINISH;
               end
               OP_MUL: begin
                  x_in     = a_ff;
                  y_in     = b_ff;
                  acc_in   = '0;
                  cnt_in   = CW'(RW);
                  ret_in   = RET_FINAL;
                  state_in = ST_MUL_DBL;
               end
               OP_POW, OP_INV, OP_DIV: begin
                  r_in       = RW'(1);
                  seen_in    = 1'b0;
                  exp_cnt_in = XCW'(XW);
                  state_in   = ST_POW_BIT;
                  if (op_ff == OP_POW) begin
                     base_in = a_ff;
                     exp_in  = XW'(b_raw_ff[EW_EFF-1:0]);
                     if (b_raw_ff[OPERAND_WIDTH-1]) begin
                        // negative exponent
                        res_in    = '0;
                        status_in = 1'b1;
                        state_in  = ST_FINISH;
                     end
                  end else begin
                     // fermat: base^(modulus - 2)
                     base_in = (op_ff == OP_DIV) ? b_ff : a_ff;
                     exp_in  = XW'(modulus_ff - RW'(2));
                  end
               end
               default: begin
                  res_in   = '0;
                  state_in = ST_FINISH;
               end
            endcase
         end

         // msb-first shift and add, one adder pass per cycle
         ST_MUL_DBL: begin
            acc_in = ua_sum;
            if (y_ff[RW-1]) begin
               state_in = ST_MUL_ADD;
            end else begin
               y_in   = y_ff << 1;
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == CW'(1)) begin
                  state_in = ST_MUL_END;
               end
            end
         end

         ST_MUL_ADD: begin
            acc_in   = ua_sum;
            y_in     = y_ff << 1;
            cnt_in   = cnt_ff - 1'b1;
            state_in = (cnt_ff == CW'(1)) ? ST_MUL_END : ST_MUL_DBL;
         end

         ST_MUL_END: begin
            unique case (ret_ff)
               RET_SQR: begin
                  r_in = acc_ff;
                  if (exp_ff[XW-1]) begin
                     x_in     = acc_ff;
                     y_in     = base_ff;
                     acc_in   = '0;
                     cnt_in   = CW'(RW);
                     ret_in   = RET_MULB;
                     state_in = ST_MUL_DBL;
                  end else begin
                     exp_in     = exp_ff << 1;
                     exp_cnt_in = exp_cnt_ff - 1'b1;
                     state_in   = ST_POW_BIT;
                  end
               end
               RET_MULB: begin
                  r_in       = acc_ff;
                  exp_in     = exp_ff << 1;
                  exp_cnt_in = exp_cnt_ff - 1'b1;
                  state_in   = ST_POW_BIT;
               end
               RET_FINAL: begin
                  res_in   = acc_ff;
                  state_in = ST_FINISH;
               end
               default: state_in = ST_FINISH;
            endcase
         end

         // square-and-multiply, msb first, leading zero bits skipped
         ST_POW_BIT: begin
            if (exp_cnt_ff == '0) begin
               if (op_ff == OP_DIV) begin
                  x_in     = a_ff;
                  y_in     = r_ff;
                  acc_in   = '0;
                  cnt_in   = CW'(RW);
                  ret_in   = RET_FINAL;
                  state_in = ST_MUL_DBL;
               end else begin
                  res_in   = r_ff;
                  state_in = ST_FINISH;
               end
            end else if (!seen_ff && !exp_ff[XW-1]) begin
               exp_in     = exp_ff << 1;
               exp_cnt_in = exp_cnt_ff - 1'b1;
            end else begin
               seen_in  = 1'b1;
               x_in     = r_ff;
               y_in     = r_ff;
               acc_in   = '0;
               cnt_in   = CW'(RW);
               ret_in   = RET_SQR;
               state_in = ST_MUL_DBL;
            end
         end

         ST_FINISH: begin
            // wait for the response register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = res_ff;
               rsp_stat_in  = status_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // residue of an operand is complete
      if (store) begin
         if (!sel_b_ff) begin
            a_in     = ua_sum;
            sel_b_in = 1'b1;
            mag_in   = b_mag;
            neg_in   = b_raw_ff[OPERAND_WIDTH-1];
            acc_in   = '0;
            cnt_in   = CW'(OPERAND_WIDTH);
            state_in = ST_RED;
         end else begin
            b_in     = ua_sum;
            state_in = ST_OPER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= MOD_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         modulus_ff   <= modulus_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff      <= ret_in;
      op_ff       <= op_in;
      b_raw_ff    <= b_raw_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      sel_b_ff    <= sel_b_in;
      cnt_ff      <= cnt_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      acc_ff      <= acc_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      r_ff        <= r_in;
      base_ff     <= base_in;
      exp_ff      <= exp_in;
      exp_cnt_ff  <= exp_cnt_in;
      seen_ff     <= seen_in;
      res_ff      <= res_in;
      status_ff   <= status_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_stat_ff <= rsp_stat_in;
   end

endmodule

`default_nettype wire

### rtl/mau_modadd.sv
// mau_modadd: shared modular add / subtract unit
// x + y + cin or x - y, folded back into [0, modulus); uses mau_pkg
`timescale 1ns / 1ps
`default_nettype none

module mau_modadd
   import mau_pkg::*;
#(
   parameter int WIDTH = RESIDUE_WIDTH_DEF
) (
   input  wire modop_type        ctl,
   input  wire logic [WIDTH-1:0] modulus,
   input  wire logic [WIDTH-1:0] x,
   input  wire logic [WIDTH-1:0] y,
   output logic      [WIDTH-1:0] sum
);

   logic [WIDTH:0]   y_op;
   logic [WIDTH:0]   raw;
   logic [WIDTH+1:0] less_m;
   logic [WIDTH:0]   plus_m;

   always_comb begin
      // subtract as x + ~y + 1
      y_op   = ctl.sub ? ~{1'b0, y} : {1'b0, y};
      raw    = {1'b0, x} + y_op + {{WIDTH{1'b0}}, (ctl.sub | ctl.cin)};
      less_m = {1'b0, raw} - {2'b00, modulus};
      plus_m = raw + {1'b0, modulus};
      if (ctl.sub) begin
         // sign of the difference sits in the top bit
         sum = raw[WIDTH] ? plus_m[WIDTH-1:0] : raw[WIDTH-1:0];
      end else begin
         sum = less_m[WIDTH+1] ? raw[WIDTH-1:0] : less_m[WIDTH-1:0];
      end
   end

endmodule

`default_nettype wire

### rtl/mau_checker.sv
// mau_checker: port-level assertions for the modular arithmetic unit
// bound to modular_arithmetic_unit; uses mau_pkg
`timescale 1ns / 1ps
`default_nettype none

module mau_checker
   import mau_pkg::*;
#(
   parameter int RESIDUE_WIDTH = RESIDUE_WIDTH_DEF
) (
   input wire logic                                     clock,
   input wire logic                                     reset,
   input wire logic                                     req_tvalid,
   input wire logic                                     req_tready,
   input wire logic                                     rsp_tvalid,
   input wire logic                                     rsp_tready,
   input wire logic [((RESIDUE_WIDTH+7)/8)*8-1:0]       rsp_tdata,
   input wire logic                                     rsp_tuser
);

   // one request in flight: no request taken on the cycle after one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in progress");

   // a negative exponent always answers zero
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("error status with a nonzero result");

   // reset empties the response register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response changed");

endmodule

bind modular_arithmetic_unit mau_checker #(
   .RESIDUE_WIDTH (RESIDUE_WIDTH)
) u_mau_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
